/* src/ccr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the clock replacement cache
// Field widths of the word ports and the mode encoding.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int KeyW = 32;  // key and evicted key width
  localparam int CfgW = 5;   // capacity register width
  localparam int OccW = 5;   // occupancy field width

  typedef enum logic [1:0] {
    ModeGet   = 2'd0,
    ModePut   = 2'd1,
    ModeTick  = 2'd2,
    ModeClear = 2'd3
  } mode_e;

endpackage

/* src/clock_replacement_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_cache_core: fully associative key store with clock
// (second chance) replacement
//
// Usage: present a word (mode_i, key_i) on the input channel; one result word
// (hit_o, evicted_o, evicted_key_o, occupancy_o) comes back per input word.
// Modes: get marks a hit used; put marks a hit used, fills the lowest free
// slot below capacity, or sweeps the clock hand to evict a victim; tick runs
// the hand up to the first unused slot; clear empties the store.
// Keys live in a RAM and are compared one slot per cycle by one comparator;
// the hand sweep also visits one slot per cycle.
// One word is worked on at a time; in_ready_o is high only when the
// sequencer is idle, so a new word is taken only after the last one has
// left the sequencer. The result sits in an output register, so the next
// word is taken while a stalled result still waits; a second finished
// result holds until the receiver drains the first. Reset empties the
// store, zeroes the hand and sets capacity to 16; the user must write the
// capacity register only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module clock_replacement_cache_core
  import ccr_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic [KeyW-1:0] key_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            hit_o,
  output logic            evicted_o,
  output logic [KeyW-1:0] evicted_key_o,
  output logic [OccW-1:0] occupancy_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLookup = 3'd1;
  localparam logic [2:0] StSweep  = 3'd2;
  localparam logic [2:0] StEvict  = 3'd3;
  localparam logic [2:0] StResp   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] use_q, use_d;
  logic [IdxW-1:0]  hand_q, hand_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CfgW-1:0]  cap_q, cap_d;

  // lookup scan: issue side and compare side of the RAM read
  logic [IdxW-1:0]  scan_q, scan_d;
  logic             issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             free_fnd_q, free_fnd_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;

  // latched input word
  mode_e            mode_q, mode_d;
  logic [KeyW-1:0]  key_q, key_d;

  // pending result and output register
  logic             res_hit_q, res_hit_d;
  logic             res_ev_q, res_ev_d;
  logic [KeyW-1:0]  res_evk_q, res_evk_d;
  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_ev_q;
  logic [KeyW-1:0]  out_evk_q;
  logic [OccW-1:0]  out_occ_q;
  logic             out_load;

  // key RAM
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [KeyW-1:0]  ram_wdata, ram_rdata;

  logic             hit_now;
  logic [IdxW-1:0]  free_sel;
  logic [IdxW-1:0]  hand_next;
  logic [CmpW-1:0]  cap_ext, eff_cap, cnt_ext;

  ccr_ram #(
    .Width (KeyW),
    .Depth (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective capacity: zero acts as one, anything above SLOTS saturates.
  assign cap_ext = CmpW'(cap_q);
  assign cnt_ext = CmpW'(cnt_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(SLOTS)) begin
      eff_cap = CmpW'(SLOTS);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hand_next = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  // the one shared comparator: slot key read last cycle against the key
  assign hit_now   = cmp_vld_q && valid_q[cmp_idx_q] && (ram_rdata == key_q);
  // lowest free slot; when none was seen earlier the last slot is the free one
  assign free_sel  = free_fnd_q ? free_idx_q : cmp_idx_q;
  assign ram_raddr = (state_q == StLookup) ? scan_q : hand_q;

  assign cap_d = cfg_we_i ? cfg_data_i : cap_q;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    use_d      = use_q;
    hand_d     = hand_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    issue_d    = issue_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    mode_d     = mode_q;
    key_d      = key_q;
    res_hit_d  = res_hit_q;
    res_ev_d   = res_ev_q;
    res_evk_d  = res_evk_q;
    ram_we     = 1'b0;
    ram_waddr  = hand_q;
    ram_wdata  = key_q;
    out_load   = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mode_d    = mode_e'(mode_i);
          key_d     = key_i;
          res_hit_d = 1'b0;
          res_ev_d  = 1'b0;
          res_evk_d = '0;
          case (mode_e'(mode_i))
            ModeClear: begin
              valid_d = '0;
              use_d   = '0;
              hand_d  = '0;
              cnt_d   = '0;
              state_d = StResp;
            end
            ModeTick: begin
              // empty store: nothing to sweep
              state_d = (cnt_q == '0) ? StResp : StSweep;
            end
            default: begin
              scan_d     = '0;
              issue_d    = 1'b1;
              cmp_vld_d  = 1'b0;
              free_fnd_d = 1'b0;
              state_d    = StLookup;
            end
          endcase
        end
      end

      StLookup: begin
        // issue one RAM read per cycle, compare it the cycle after
        cmp_vld_d = issue_q;
        cmp_idx_d = scan_q;
        if (issue_q) begin
          if (scan_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
        if (cmp_vld_q) begin
          if (!valid_q[cmp_idx_q] && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (hit_now) begin
            use_d[cmp_idx_q] = 1'b1;
            res_hit_d        = 1'b1;
            state_d          = StResp;
          end else if (cmp_idx_q == LastIdx) begin
            if (mode_q == ModePut) begin
              if (cnt_ext < eff_cap) begin
                // fill the lowest free slot
                ram_we          = 1'b1;
                ram_waddr       = free_sel;
                valid_d[free_sel] = 1'b1;
                use_d[free_sel] = 1'b1;
                cnt_d           = cnt_q + 1'b1;
                state_d         = StResp;
              end else begin
                state_d = StSweep;
              end
            end else begin
              state_d = StResp;
            end
          end
        end
      end

      StSweep: begin
        // one slot per cycle: stop on a valid unused slot, else clear and advance
        if (valid_q[hand_q] && !use_q[hand_q]) begin
          state_d = (mode_q == ModePut) ? StEvict : StResp;
        end else begin
          if (valid_q[hand_q]) begin
            use_d[hand_q] = 1'b0;
          end
          hand_d = hand_next;
        end
      end

      StEvict: begin
        // victim key was read at the hand last cycle; replace it
        res_ev_d      = 1'b1;
        res_evk_d     = ram_rdata;
        ram_we        = 1'b1;
        ram_waddr     = hand_q;
        use_d[hand_q] = 1'b1;
        hand_d        = hand_next;
        state_d       = StResp;
      end

      StResp: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      use_q       <= '0;
      hand_q      <= '0;
      cnt_q       <= '0;
      cap_q       <= CfgW'(16);
      scan_q      <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      use_q       <= use_d;
      hand_q      <= hand_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      scan_q      <= scan_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      free_fnd_q  <= free_fnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    res_hit_q  <= res_hit_d;
    res_ev_q   <= res_ev_d;
    res_evk_q  <= res_evk_d;
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_ev_q  <= res_ev_q;
      out_evk_q <= res_evk_q;
      out_occ_q <= OccW'(cnt_q);
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evk_q;
  assign occupancy_o   = out_occ_q;

endmodule

/* src/ccr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccr_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/clock_replacement_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_cache_checker: scoreboard of the clock replacement cache
// Watches the capacity port and both word channels, keeps its own image of
// the slots, use bits, hand and occupancy, and compares every result word.
// ----------------------------------------------------------------------------
module clock_replacement_cache_checker
  import ccr_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [1:0]      mode_i,
  input  logic [KeyW-1:0] key_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic            hit_i,
  input  logic            evicted_i,
  input  logic [KeyW-1:0] evicted_key_i,
  input  logic [OccW-1:0] occupancy_i,
  output int              pending_o,
  output int              mismatch_count_o,
  output int              checked_o,
  output int              hit_count_o,
  output int              evict_count_o
);

  localparam int HandW = $clog2(SLOTS);

  typedef struct packed {
    logic            hit;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
    logic [OccW-1:0] occupancy;
  } cache_outcome_t;

  logic [KeyW-1:0]  slot_key [SLOTS];
  logic [SLOTS-1:0] slot_live;
  logic [SLOTS-1:0] slot_used;
  logic [HandW-1:0] hand;
  logic [OccW-1:0]  live_count;
  logic [CfgW-1:0]  capacity;
  cache_outcome_t   awaited_outcomes [$];
  cache_outcome_t   oldest;

  function automatic int find_slot(logic [KeyW-1:0] key);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_live[s] && slot_key[s] == key) return s;
    end
    return -1;
  endfunction

  // Run the hand to the first live slot with a clear use bit, giving each
  // used slot its second chance on the way.
  function automatic int sweep_hand();
    int s;
    for (int n = 0; n < 2 * SLOTS; n++) begin
      s = hand;
      if (slot_live[s]) begin
        if (!slot_used[s]) return s;
        slot_used[s] = 1'b0;
      end
      hand = HandW'((s + 1) % SLOTS);
    end
    return -1;
  endfunction

  function automatic cache_outcome_t compute_cache_outcome(mode_e mode, logic [KeyW-1:0] key);
    cache_outcome_t res;
    int             slot;
    int             limit;
    bit             placed;
    res = '0;
    limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
    case (mode)
      ModeGet: begin
        slot = find_slot(key);
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          res.hit = 1'b1;
        end
      end
      ModePut: begin
        slot = find_slot(key);
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          res.hit = 1'b1;
        end else if (int'(live_count) < limit) begin
          placed = 1'b0;
          for (int s = 0; s < SLOTS; s++) begin
            if (!placed && !slot_live[s]) begin
              slot_live[s] = 1'b1;
              slot_key[s]  = key;
              slot_used[s] = 1'b1;
              live_count   = live_count + 1'b1;
              placed       = 1'b1;
            end
          end
        end else begin
          slot = sweep_hand();
          if (slot >= 0) begin
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[slot];
            slot_key[slot]  = key;
            slot_used[slot] = 1'b1;
            hand            = HandW'((slot + 1) % SLOTS);
          end
        end
      end
      ModeTick: begin
        if (live_count != 0) void'(sweep_hand());
      end
      default: begin
        slot_live  = '0;
        slot_used  = '0;
        hand       = '0;
        live_count = '0;
      end
    endcase
    res.occupancy = live_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [KeyW-1:0] want_v,
                             input logic [KeyW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_live        = '0;
      slot_used        = '0;
      hand             = '0;
      live_count       = '0;
      capacity         = CfgW'(16);
      awaited_outcomes.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
      checked_o        = 0;
      hit_count_o      = 0;
      evict_count_o    = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        awaited_outcomes.push_back(compute_cache_outcome(mode_e'(mode_i), key_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result word, actual hit %0b evicted %0b key %0h occ %0d",
                   $time, hit_i, evicted_i, evicted_key_i, occupancy_i);
          mismatch_count_o++;
        end else begin
          oldest = awaited_outcomes.pop_front();
          check_field("hit", oldest.hit, hit_i);
          check_field("evicted", oldest.evicted, evicted_i);
          check_field("evicted_key", oldest.evicted_key, evicted_key_i);
          check_field("occupancy", oldest.occupancy, occupancy_i);
          checked_o++;
          if (oldest.hit) hit_count_o++;
          if (oldest.evicted) evict_count_o++;
        end
      end
      pending_o = awaited_outcomes.size();
    end
  end

endmodule

/* dv/clock_replacement_cache_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_cache_core_tb: stimulus and verdict for the cache core
// Drives a directed opening and then random get/put/tick/clear words over a
// series of capacity settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module clock_replacement_cache_core_tb;
  import ccr_pkg::*;

  localparam int SLOTS      = 16;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 120;  // random words per capacity setting
  localparam int POOL_DEPTH = 24;
  localparam int DRAIN_WAIT = 3 * SLOTS + 4;  // extra watch after the drain for stray result words

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  mode_e           mode_i = ModeGet;
  logic [KeyW-1:0] key_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            hit_o;
  logic            evicted_o;
  logic [KeyW-1:0] evicted_key_o;
  logic [OccW-1:0] occupancy_o;

  int pending;
  int mismatches;
  int checked;
  int hits;
  int evictions;

  // Capacity for each random phase. The store is not cleared between phases,
  // so dropping from a large setting to a small one leaves occupancy above
  // capacity; zero-like and oversized settings sit among them.
  logic [CfgW-1:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17,
                                           5'd5, 5'd2, 5'd12, 5'd16, 5'd4};

  logic [KeyW-1:0] key_pool [POOL_DEPTH];
  int              pool_span;
  int              burst_left;
  int              gap;
  int              words_sent;
  int              settings_used;
  int              eff_cap;

  // receiver stall pattern state
  int              stall_style;
  int              stall_left = 0;
  int              rx_cycle = 0;

  always #6 clk_i = ~clk_i;

  clock_replacement_cache_core #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .occupancy_o   (occupancy_o)
  );

  clock_replacement_cache_checker #(
    .SLOTS(SLOTS)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .mode_i           (mode_i),
    .key_i            (key_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_i            (hit_o),
    .evicted_i        (evicted_o),
    .evicted_key_i    (evicted_key_o),
    .occupancy_i      (occupancy_o),
    .pending_o        (pending),
    .mismatch_count_o (mismatches),
    .checked_o        (checked),
    .hit_count_o      (hits),
    .evict_count_o    (evictions)
  );

  // Receiver: switch to a random stall style whenever the current one runs
  // out. Styles are always ready, coin flip, mostly stalled and a fixed periodic beat.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(50, 300);
    end
    stall_left--;
    rx_cycle++;
    case (stall_style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rx_cycle % 5 == 0);
    endcase
  end

  // Present one word at a falling edge and hold it until accepted; return at
  // the falling edge after acceptance with valid still high.
  task automatic send_word(input mode_e m, input logic [KeyW-1:0] k);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    key_i      <= k;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write capacity while idle: one cycle of write enable.
  task automatic write_capacity(input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  function automatic mode_e pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ModeGet;
    if (r < 82) return ModePut;
    if (r < 97) return ModeTick;
    return ModeClear;
  endfunction

  // Mostly draw from a small pool so gets and puts hit; now and then use a
  // fresh random key.
  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, pool_span - 1)];
  endfunction

  initial begin
    words_sent    = 0;
    settings_used = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening at reset capacity: misses and a tick on an empty store,
    // fills, hits, a full second-chance tick and a clear.
    send_word(ModeGet, 32'h0000_0000);
    send_word(ModeTick, 32'h0000_0000);
    send_word(ModePut, 32'h0000_0000);
    send_word(ModePut, 32'hFFFF_FFFF);
    send_word(ModePut, 32'h0000_0000);
    send_word(ModeGet, 32'hFFFF_FFFF);
    send_word(ModeGet, 32'h1234_5678);
    send_word(ModeTick, 32'hFFFF_FFFF);
    send_word(ModeTick, 32'h0000_0000);
    send_word(ModeClear, 32'h0000_0000);
    send_word(ModeGet, 32'h0000_0000);
    wait_idle();

    // Capacity two: evictions after a full sweep, tick, reinsert, clear.
    write_capacity(5'd2);
    send_word(ModePut, 32'hA5A5_A5A5);
    send_word(ModePut, 32'h5A5A_5A5A);
    send_word(ModePut, 32'h0F0F_0F0F);
    send_word(ModeGet, 32'h5A5A_5A5A);
    send_word(ModePut, 32'h3333_3333);
    send_word(ModeTick, 32'h0000_0000);
    send_word(ModePut, 32'hA5A5_A5A5);
    send_word(ModeClear, 32'h0000_0000);
    wait_idle();

    // Capacity zero behaves as one slot.
    write_capacity(5'd0);
    send_word(ModePut, 32'h0000_0001);
    send_word(ModePut, 32'h0000_0002);
    send_word(ModeGet, 32'h0000_0002);
    send_word(ModeClear, 32'h0000_0000);

    // Random phases; each starts with the sender paused until drained.
    burst_left = $urandom_range(1, 30);
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] == 0) ? 1 :
                ((phase_caps[p] > SLOTS) ? SLOTS : int'(phase_caps[p]));
      pool_span = eff_cap + $urandom_range(1, 8);
      if (pool_span > POOL_DEPTH) pool_span = POOL_DEPTH;
      for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        send_word(pick_mode(), pick_key());
        burst_left--;
        if (burst_left == 0) begin
          // end of burst: either run straight on or idle for a while
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(negedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
      end
    end

    // Drain, then watch a little longer for stray result words.
    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Covered %0d words over %0d capacity settings: %0d results checked,",
             words_sent, settings_used + 1, checked);
    $display("  %0d hits and %0d evictions seen.", hits, evictions);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
